### rtl/stt_pkg.sv
// stt_pkg: shared types and constants for the source text tokenizer
// item structs for both channels, lexer modes, codes and character constants
// no dependencies
package stt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_INT   = 3'd1,
        MODE_FRAC  = 3'd2,
        MODE_IDENT = 3'd3,
        MODE_CHR   = 3'd4,
        MODE_STR   = 3'd5,
        MODE_STOP  = 3'd6
    } lex_mode_t;

    typedef enum logic [3:0] {
        CC_DIGIT,
        CC_LETTER,
        CC_OP,
        CC_SEP,
        CC_SQUOTE,
        CC_DQUOTE,
        CC_NUL,
        CC_SPACE,
        CC_OTHER
    } char_class_t;

    localparam logic       CMD_BYTE = 1'b0;
    localparam logic       CMD_EOF  = 1'b1;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_EOF     = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [2:0] CLS_NUM   = 3'd0;
    localparam logic [2:0] CLS_IDENT = 3'd1;
    localparam logic [2:0] CLS_OP    = 3'd2;
    localparam logic [2:0] CLS_SEP   = 3'd3;
    localparam logic [2:0] CLS_CHR   = 3'd4;
    localparam logic [2:0] CLS_STR   = 3'd5;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_value;
    } src_item_t;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [2:0] token_class;
        logic [7:0] byte_out;
        logic       token_first;
        logic       token_closed_here;
        logic       unterminated;
        logic       run_last;
    } tok_item_t;

    // results of one accepted item handed from the front to the queue
    typedef struct packed {
        logic [1:0] count;
        tok_item_t  first;
        tok_item_t  second;
    } tok_push_t;

endpackage

### rtl/stt_front.sv
// stt_front: classifies each accepted source item against the lexer mode
// and produces up to two result transactions per item
// depends on stt_pkg
module stt_front
    import stt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  src_item_t item,
    output tok_push_t push
);

    lex_mode_t   mode_reg;
    lex_mode_t   mode_next;
    lex_mode_t   start_mode;
    char_class_t cc;
    tok_item_t   start_res;
    logic        start_emit;
    tok_item_t   r0;
    tok_item_t   r1;
    logic [1:0]  n;
    logic [7:0]  c;

    function automatic char_class_t classify(input logic [7:0] b);
        char_class_t r;
        r = CC_OTHER;
        if (b >= CH_ZERO && b <= CH_NINE)
            r = CC_DIGIT;
        else if ((b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a))
            r = CC_LETTER;
        else
        begin
            unique case (b) inside
                8'h3c, 8'h3e, 8'h2f, 8'h2a, 8'h2b, 8'h2d, 8'h25, 8'h5e, 8'h24, 8'h21,
                8'h3d, 8'h7c, 8'h3f, 8'h7e, 8'h23, 8'h3a, 8'h3b, 8'h5c, 8'h2e, 8'h26:
                    r = CC_OP;
                8'h5b, 8'h5d, 8'h28, 8'h29, 8'h7b, 8'h7d, 8'h2c:
                    r = CC_SEP;
                8'h27:   r = CC_SQUOTE;
                8'h22:   r = CC_DQUOTE;
                8'h00:   r = CC_NUL;
                8'h20, 8'h09, 8'h0a, 8'h0d:
                    r = CC_SPACE;
                default: r = CC_OTHER;
            endcase
        end
        return r;
    endfunction

    function automatic tok_item_t mk(input logic [1:0] kind, input logic [2:0] cls,
                                     input logic [7:0] b, input logic first,
                                     input logic closed, input logic unterm);
        tok_item_t t;
        t.item_kind         = kind;
        t.token_class       = cls;
        t.byte_out          = b;
        t.token_first       = first;
        t.token_closed_here = closed;
        t.unterminated      = unterm;
        t.run_last          = 1'b0;
        return t;
    endfunction

    assign c  = item.char_value;
    assign cc = classify(c);

    // what a byte does when no token is open
    always_comb
    begin
        start_emit = 1'b1;
        start_mode = MODE_IDLE;
        start_res  = mk(KIND_UNKNOWN, CLS_NUM, c, 1'b0, 1'b0, 1'b0);
        unique case (cc)
            CC_DIGIT:
            begin
                start_res  = mk(KIND_BYTE, CLS_NUM, c, 1'b1, 1'b0, 1'b0);
                start_mode = MODE_INT;
            end
            CC_LETTER:
            begin
                start_res  = mk(KIND_BYTE, CLS_IDENT, c, 1'b1, 1'b0, 1'b0);
                start_mode = MODE_IDENT;
            end
            CC_OP:     start_res = mk(KIND_BYTE, CLS_OP, c, 1'b1, 1'b1, 1'b0);
            CC_SEP:    start_res = mk(KIND_BYTE, CLS_SEP, c, 1'b1, 1'b1, 1'b0);
            CC_SQUOTE:
            begin
                start_res  = mk(KIND_BYTE, CLS_CHR, c, 1'b1, 1'b0, 1'b0);
                start_mode = MODE_CHR;
            end
            CC_DQUOTE:
            begin
                start_res  = mk(KIND_BYTE, CLS_STR, c, 1'b1, 1'b0, 1'b0);
                start_mode = MODE_STR;
            end
            CC_NUL:
            begin
                start_emit = 1'b0;
                start_mode = MODE_STOP;
            end
            CC_SPACE:  start_emit = 1'b0;
            default:   start_emit = 1'b1;
        endcase
    end

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (item.cmd == CMD_EOF)
            mode_next = MODE_IDLE;
        else
        begin
            unique case (mode_reg)
                MODE_STOP:  mode_next = MODE_STOP;
                MODE_CHR:   mode_next = (c == CH_SQUOTE) ? MODE_IDLE : MODE_CHR;
                MODE_STR:   mode_next = (c == CH_DQUOTE) ? MODE_IDLE : MODE_STR;
                MODE_INT:
                    if (cc == CC_DIGIT)
                        mode_next = MODE_INT;
                    else if (c == CH_DOT)
                        mode_next = MODE_FRAC;
                    else
                        mode_next = start_mode;
                MODE_FRAC:  mode_next = (cc == CC_DIGIT) ? MODE_FRAC : start_mode;
                MODE_IDENT:
                    mode_next = (cc == CC_LETTER || c == CH_UNDER) ? MODE_IDENT : start_mode;
                default:    mode_next = start_mode;
            endcase
        end
    end

    // results of this item
    always_comb
    begin
        n  = 2'd0;
        r0 = mk(KIND_EOF, CLS_NUM, 8'h00, 1'b0, 1'b0, 1'b0);
        r1 = mk(KIND_EOF, CLS_NUM, 8'h00, 1'b0, 1'b0, 1'b0);
        if (item.cmd == CMD_EOF)
        begin
            n = 2'd2;
            unique case (mode_reg) inside
                MODE_INT, MODE_FRAC:
                    r0 = mk(KIND_END, CLS_NUM, 8'h00, 1'b0, 1'b0, 1'b0);
                MODE_IDENT:
                    r0 = mk(KIND_END, CLS_IDENT, 8'h00, 1'b0, 1'b0, 1'b0);
                MODE_CHR:
                    r0 = mk(KIND_END, CLS_CHR, 8'h00, 1'b0, 1'b0, 1'b1);
                MODE_STR:
                    r0 = mk(KIND_END, CLS_STR, 8'h00, 1'b0, 1'b0, 1'b1);
                default:
                    n = 2'd1;
            endcase
        end
        else
        begin
            unique case (mode_reg) inside
                MODE_STOP: n = 2'd0;
                MODE_CHR:
                begin
                    n  = 2'd1;
                    r0 = mk(KIND_BYTE, CLS_CHR, c, 1'b0, c == CH_SQUOTE, 1'b0);
                end
                MODE_STR:
                begin
                    n  = 2'd1;
                    r0 = mk(KIND_BYTE, CLS_STR, c, 1'b0, c == CH_DQUOTE, 1'b0);
                end
                MODE_INT, MODE_FRAC:
                    if (cc == CC_DIGIT || (mode_reg == MODE_INT && c == CH_DOT))
                    begin
                        n  = 2'd1;
                        r0 = mk(KIND_BYTE, CLS_NUM, c, 1'b0, 1'b0, 1'b0);
                    end
                    else
                    begin
                        n  = start_emit ? 2'd2 : 2'd1;
                        r0 = mk(KIND_END, CLS_NUM, 8'h00, 1'b0, 1'b0, 1'b0);
                        r1 = start_res;
                    end
                MODE_IDENT:
                    if (cc == CC_LETTER || c == CH_UNDER)
                    begin
                        n  = 2'd1;
                        r0 = mk(KIND_BYTE, CLS_IDENT, c, 1'b0, 1'b0, 1'b0);
                    end
                    else
                    begin
                        n  = start_emit ? 2'd2 : 2'd1;
                        r0 = mk(KIND_END, CLS_IDENT, 8'h00, 1'b0, 1'b0, 1'b0);
                        r1 = start_res;
                    end
                default:
                begin
                    n  = start_emit ? 2'd1 : 2'd0;
                    r0 = start_res;
                end
            endcase
        end
        if (n == 2'd2)
            r1.run_last = 1'b1;
        else if (n == 2'd1)
            r0.run_last = 1'b1;
    end

    assign push.count  = accept ? n : 2'd0;
    assign push.first  = r0;
    assign push.second = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_IDLE;
        else if (accept)
            mode_reg <= mode_next;
    end

endmodule

### rtl/stt_queue.sv
// stt_queue: four-entry result queue, two writes and one read per cycle
// its head drives the result channel directly from registers
// depends on stt_pkg
module stt_queue
    import stt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tok_push_t push,
    output logic      room,
    output logic      tok_valid,
    input  logic      tok_ready,
    output tok_item_t tok_item
);

    localparam int Depth = 4;

    tok_item_t  mem [Depth];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    assign tok_valid = (count_reg != 3'd0);
    assign tok_item  = mem[rd_ptr_reg];
    assign pop       = tok_valid && tok_ready;
    // two free slots cover the worst item
    assign room      = (count_reg <= 3'd2);

    assign wr_ptr_next = wr_ptr_reg + push.count;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_reg + 2'd1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/source_text_tokenizer.sv
// source text tokenizer: one source byte or end of file per transaction in,
// one result per transaction out; accepts one item per cycle while the queue has
// two free slots; items giving two results need two transfers on the result port,
// the only single-result-per-cycle unit; the four-entry queue absorbs bursts;
// rst_n (async, active low) clears the lexer mode to between tokens and empties
// the queue
module source_text_tokenizer
    import stt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  src_item_t src_item,
    output logic      tok_valid,
    input  logic      tok_ready,
    output tok_item_t tok_item
);

    tok_push_t push;
    logic      accept;

    assign accept = src_valid && src_ready;

    stt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (src_item),
        .push   (push)
    );

    stt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (src_ready),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_item  (tok_item)
    );

endmodule

### rtl/stt_checker.sv
// stt_checker: port-level checks for the source text tokenizer
// bound to the top level; depends on stt_pkg
module stt_checker
    import stt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      src_valid,
    input logic      src_ready,
    input src_item_t src_item,
    input logic      tok_valid,
    input logic      tok_ready,
    input tok_item_t tok_item
);

    // a held result keeps its payload
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(tok_item))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !tok_valid)
        else $error("result valid after reset");

    // back-pressure on the source side only when results are queued
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !src_ready |-> tok_valid)
        else $error("source stalled with no pending result");

    // unterminated only closes literals
    a_unterm: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.unterminated |->
            tok_item.item_kind == KIND_END &&
            (tok_item.token_class == CLS_CHR || tok_item.token_class == CLS_STR))
        else $error("unterminated flag on a non-literal result");

    // end of file is always the last result of its item
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.item_kind == KIND_EOF |-> tok_item.run_last)
        else $error("end of file not last");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);
